// ===== hdl/dbms_pkg.sv =====
// Shared types and codes for the doubling/bisection margin search sequencer.
package dbms_pkg;

	localparam int DelayW = 32;
	localparam int ShiftW = 5;
	localparam int CfgIdxW = 2;

	// operation codes
	localparam logic OP_START  = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	// search phases
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_CONTROL = 2'd1;
	localparam logic [1:0] PH_RAMP    = 2'd2;
	localparam logic [1:0] PH_BISECT  = 2'd3;

	// final status codes
	localparam logic [1:0] ST_BOUNDED = 2'd0;
	localparam logic [1:0] ST_ABOVE   = 2'd1;
	localparam logic [1:0] ST_CONTROL = 2'd2;
	localparam logic [1:0] ST_ABORTED = 2'd3;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_LIMIT = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_START = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_SHIFT = 2'd2;

	typedef struct packed {
		logic [DelayW-1:0] limit_delay;
		logic [DelayW-1:0] start_delay;
		logic [ShiftW-1:0] precision_shift;
	} dbms_cfg_t;

	typedef struct packed {
		logic [1:0]        phase;
		logic [DelayW-1:0] cur_delay;
		logic [DelayW-1:0] pass_bound;
		logic [DelayW-1:0] fail_bound;
	} dbms_state_t;

	typedef struct packed {
		logic              trial_request;
		logic [DelayW-1:0] trial_delay;
		logic              reported;
		logic [DelayW-1:0] reported_delay;
		logic              reported_ok;
		logic              done_res;
		logic [1:0]        status;
		logic [DelayW-1:0] good_delay;
		logic [DelayW-1:0] bad_delay;
	} dbms_res_t;

endpackage

// ===== hdl/dbms_cfg.sv =====
// Configuration register file: limit, start delay and precision shift.
module dbms_cfg import dbms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DelayW-1:0]  cfg_data,
	output dbms_cfg_t          cfg
);

	dbms_cfg_t cfg_q;

	// always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// register decode; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit_delay     <= '0;
			cfg_q.start_delay     <= DelayW'(64);
			cfg_q.precision_shift <= ShiftW'(4);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LIMIT: cfg_q.limit_delay     <= cfg_data;
				REG_START: cfg_q.start_delay     <= cfg_data;
				REG_SHIFT: cfg_q.precision_shift <= cfg_data[ShiftW-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/dbms_step.sv =====
// Next-state and result logic for one word of the search sequencer.
module dbms_step import dbms_pkg::*; #(
	parameter logic [DelayW-1:0] DEFAULT_LIMIT = 32'd1048576
) (
	input  dbms_cfg_t   cfg,
	input  dbms_state_t cur,
	input  logic        operation,
	input  logic        trial_ok,
	input  logic        abort_requested,
	output dbms_state_t nxt,
	output dbms_res_t   res
);

	logic [DelayW-1:0] eff_limit;
	logic [DelayW-1:0] eff_start;
	logic              bis_pass;
	logic [DelayW-1:0] bp;
	logic [DelayW-1:0] bf;
	logic [DelayW-1:0] gap;
	logic [DelayW:0]   thr;
	logic              gap_small;
	logic [DelayW-1:0] mid;
	logic [DelayW:0]   dbl;
	logic              dbl_over;

	assign eff_limit = (cfg.limit_delay != '0) ? cfg.limit_delay : DEFAULT_LIMIT;
	assign eff_start = (cfg.start_delay != '0) ? cfg.start_delay : DelayW'(1);

	// candidate bounds after a ramp fail or a bisection trial
	assign bis_pass = (cur.phase == PH_BISECT) && trial_ok;
	assign bp = bis_pass ? cur.cur_delay : cur.pass_bound;
	assign bf = bis_pass ? cur.fail_bound : cur.cur_delay;

	// stop rule: gap <= (good >> shift) + 1, kept one bit wider
	assign gap = bf - bp;
	assign thr = {1'b0, bp >> cfg.precision_shift} + {{DelayW{1'b0}}, 1'b1};
	assign gap_small = ({1'b0, gap} <= thr);
	assign mid = bp + (gap >> 1);

	// doubled delay; top bit catches 32-bit overflow
	assign dbl = {cur.cur_delay, 1'b0};
	assign dbl_over = dbl > {1'b0, eff_limit};

	always_comb begin
		nxt = cur;
		res = '0;
		if (operation == OP_START) begin
			nxt = '0;
			nxt.phase = PH_CONTROL;
			res.trial_request = 1'b1;
		end else begin
			unique case (cur.phase)
				PH_IDLE: ;
				PH_CONTROL: begin
					if (!trial_ok) begin
						res.done_res = 1'b1;
						res.status = ST_CONTROL;
						nxt.phase = PH_IDLE;
					end else if (eff_start > eff_limit) begin
						res.done_res = 1'b1;
						res.status = ST_ABOVE;
						nxt.phase = PH_IDLE;
					end else begin
						nxt.cur_delay = eff_start;
						nxt.phase = PH_RAMP;
						res.trial_request = 1'b1;
						res.trial_delay = eff_start;
					end
				end
				PH_RAMP: begin
					res.reported = 1'b1;
					res.reported_delay = cur.cur_delay;
					res.reported_ok = trial_ok;
					if (!trial_ok) begin
						nxt.fail_bound = cur.cur_delay;
						if (gap_small) begin
							res.done_res = 1'b1;
							res.status = ST_BOUNDED;
							nxt.phase = PH_IDLE;
						end else begin
							nxt.cur_delay = mid;
							nxt.phase = PH_BISECT;
							res.trial_request = 1'b1;
							res.trial_delay = mid;
						end
					end else begin
						nxt.pass_bound = cur.cur_delay;
						if (abort_requested) begin
							res.done_res = 1'b1;
							res.status = ST_ABORTED;
							nxt.phase = PH_IDLE;
						end else if (dbl_over) begin
							res.done_res = 1'b1;
							res.status = ST_ABOVE;
							nxt.phase = PH_IDLE;
						end else begin
							nxt.cur_delay = dbl[DelayW-1:0];
							res.trial_request = 1'b1;
							res.trial_delay = dbl[DelayW-1:0];
						end
					end
				end
				PH_BISECT: begin
					res.reported = 1'b1;
					res.reported_delay = cur.cur_delay;
					res.reported_ok = trial_ok;
					nxt.pass_bound = bp;
					nxt.fail_bound = bf;
					if (abort_requested) begin
						res.done_res = 1'b1;
						res.status = ST_ABORTED;
						nxt.phase = PH_IDLE;
					end else if (gap_small) begin
						res.done_res = 1'b1;
						res.status = ST_BOUNDED;
						nxt.phase = PH_IDLE;
					end else begin
						nxt.cur_delay = mid;
						res.trial_request = 1'b1;
						res.trial_delay = mid;
					end
				end
			endcase
		end
		res.good_delay = nxt.pass_bound;
		res.bad_delay = nxt.fail_bound;
	end

endmodule

// ===== hdl/doubling_bisection_margin_search.sv =====
// Top level of the doubling/bisection margin search sequencer.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-----------------------------------------
//  in      | to block  | in_valid / in_stall | operation, trial_ok, abort_requested
//  out     | from block| out_valid/out_stall | trial request, report, status, bounds
//  cfg     | to block  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each accepted word yields one result word: the word is held in the input
// register, then passes through the step logic into the result register.
// A new word is taken every cycle while the input side is not stalled; the
// search state updates once for each word that moves to the result register.
// Reset clears the search state to idle and loads the register defaults.
// A stall on the result side holds the result and, once the input register is
// also full, stalls the input side.
module doubling_bisection_margin_search import dbms_pkg::*; #(
	parameter logic [31:0] DEFAULT_LIMIT = 32'd1048576
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic               trial_ok,
	input  logic               abort_requested,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               trial_request,
	output logic [DelayW-1:0]  trial_delay,
	output logic               reported,
	output logic [DelayW-1:0]  reported_delay,
	output logic               reported_ok,
	output logic               done_res,
	output logic [1:0]         status,
	output logic [DelayW-1:0]  good_delay,
	output logic [DelayW-1:0]  bad_delay,
	// configuration channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DelayW-1:0]  cfg_data
);

	dbms_cfg_t   cfg;
	dbms_state_t state_q;
	dbms_state_t state_nxt;
	dbms_res_t   res_nxt;
	dbms_res_t   res_q;

	logic        valid_s1;
	logic        op_s1;
	logic        ok_s1;
	logic        abort_s1;
	logic        out_valid_q;
	logic        advance;
	logic        take_in;

	dbms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dbms_step #(
		.DEFAULT_LIMIT (DEFAULT_LIMIT)
	) u_step (
		.cfg             (cfg),
		.cur             (state_q),
		.operation       (op_s1),
		.trial_ok        (ok_s1),
		.abort_requested (abort_s1),
		.nxt             (state_nxt),
		.res             (res_nxt)
	);

	// word moves from input register to result register
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1    <= operation;
			ok_s1    <= trial_ok;
			abort_s1 <= abort_requested;
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_IDLE;
			state_q.cur_delay  <= '0;
			state_q.pass_bound <= '0;
			state_q.fail_bound <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign trial_request  = res_q.trial_request;
	assign trial_delay    = res_q.trial_delay;
	assign reported       = res_q.reported;
	assign reported_delay = res_q.reported_delay;
	assign reported_ok    = res_q.reported_ok;
	assign done_res       = res_q.done_res;
	assign status         = res_q.status;
	assign good_delay     = res_q.good_delay;
	assign bad_delay      = res_q.bad_delay;

endmodule

// ===== hdl/dbms_checker.sv =====
// Port-level checks for the margin search sequencer, bound to the top level.
module dbms_checker import dbms_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic              trial_request,
	input logic [DelayW-1:0] trial_delay,
	input logic              reported,
	input logic [DelayW-1:0] reported_delay,
	input logic              reported_ok,
	input logic              done_res,
	input logic [1:0]        status,
	input logic [DelayW-1:0] good_delay,
	input logic [DelayW-1:0] bad_delay
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(trial_delay) && $stable(status)
			&& $stable(good_delay) && $stable(bad_delay))
		else $error("stalled result word changed");

	// a finished search requests no further trial
	a_done_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !trial_request)
		else $error("trial requested on a finished search");

	// a nonzero status only comes with done
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_BOUNDED) |-> done_res)
		else $error("status set without done");

	// report fields are clear when nothing is reported
	a_report_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reported |-> (reported_delay == '0) && !reported_ok)
		else $error("report fields set without a report");

	// once a failing delay is known it lies above the passing one
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (bad_delay != '0) |-> good_delay < bad_delay)
		else $error("bounds out of order");

endmodule

bind doubling_bisection_margin_search dbms_checker u_dbms_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.trial_request  (trial_request),
	.trial_delay    (trial_delay),
	.reported       (reported),
	.reported_delay (reported_delay),
	.reported_ok    (reported_ok),
	.done_res       (done_res),
	.status         (status),
	.good_delay     (good_delay),
	.bad_delay      (bad_delay)
);

// ===== tb/dbms_checker.sv =====
// Margin search checker: tracks the search state, predicts each result word and compares it.
module dbms_scoreboard import dbms_pkg::*; #(
	parameter logic [DelayW-1:0] LimitDefault = 32'd1048576
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               operation,
	input  logic               trial_ok,
	input  logic               abort_requested,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               trial_request,
	input  logic [DelayW-1:0]  trial_delay,
	input  logic               reported,
	input  logic [DelayW-1:0]  reported_delay,
	input  logic               reported_ok,
	input  logic               done_res,
	input  logic [1:0]         status,
	input  logic [DelayW-1:0]  good_delay,
	input  logic [DelayW-1:0]  bad_delay,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DelayW-1:0]  cfg_data,
	output int                 mismatches,
	output int                 n_open,
	output logic               search_live
);

	dbms_cfg_t   regs;
	dbms_state_t srch;
	dbms_res_t   due_results[$];

	// one line per mismatch
	task automatic flag(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [DelayW-1:0] got,
			input logic [DelayW-1:0] want);
		if (got !== want)
			flag($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// stop rule; tolerance kept 33 bits wide so it never wraps
	function automatic logic gap_closed();
		logic [DelayW:0] gap;
		logic [DelayW:0] tol;
		gap = {1'b0, srch.fail_bound - srch.pass_bound};
		tol = {1'b0, srch.pass_bound >> regs.precision_shift} + (DelayW+1)'(1);
		return gap <= tol;
	endfunction

	function automatic logic [DelayW-1:0] bisect_point();
		return srch.pass_bound + ((srch.fail_bound - srch.pass_bound) >> 1);
	endfunction

	function automatic void close_search(inout dbms_res_t r, input logic [1:0] code);
		r.done_res = 1'b1;
		r.status = code;
		srch.phase = PH_IDLE;
	endfunction

	function automatic void ask_trial(inout dbms_res_t r, input logic [DelayW-1:0] d);
		srch.cur_delay = d;
		r.trial_request = 1'b1;
		r.trial_delay = d;
	endfunction

	// advance the search by one word and return the result word it yields
	function automatic dbms_res_t search_step(input logic op, input logic ok, input logic ab);
		dbms_res_t         r;
		logic [DelayW-1:0] lim;
		logic [DelayW-1:0] first;
		r = '0;
		lim = (regs.limit_delay == '0) ? LimitDefault : regs.limit_delay;
		first = (regs.start_delay == '0) ? 32'd1 : regs.start_delay;
		if (op == OP_START) begin
			srch.pass_bound = '0;
			srch.fail_bound = '0;
			srch.cur_delay = '0;
			srch.phase = PH_CONTROL;
			r.trial_request = 1'b1;
		end else if (srch.phase == PH_CONTROL) begin
			if (!ok)
				close_search(r, ST_CONTROL);
			else if (first > lim)
				close_search(r, ST_ABOVE);
			else begin
				srch.phase = PH_RAMP;
				ask_trial(r, first);
			end
		end else if (srch.phase == PH_RAMP || srch.phase == PH_BISECT) begin
			r.reported = 1'b1;
			r.reported_delay = srch.cur_delay;
			r.reported_ok = ok;
			if (srch.phase == PH_RAMP && !ok) begin
				// first failure ends the ramp; no abort check here
				srch.fail_bound = srch.cur_delay;
				if (gap_closed())
					close_search(r, ST_BOUNDED);
				else begin
					srch.phase = PH_BISECT;
					ask_trial(r, bisect_point());
				end
			end else if (srch.phase == PH_RAMP) begin
				srch.pass_bound = srch.cur_delay;
				if (ab)
					close_search(r, ST_ABORTED);
				else if (srch.cur_delay[DelayW-1] || (srch.cur_delay << 1) > lim)
					close_search(r, ST_ABOVE);
				else
					ask_trial(r, srch.cur_delay << 1);
			end else begin
				if (ok)
					srch.pass_bound = srch.cur_delay;
				else
					srch.fail_bound = srch.cur_delay;
				if (ab)
					close_search(r, ST_ABORTED);
				else if (gap_closed())
					close_search(r, ST_BOUNDED);
				else
					ask_trial(r, bisect_point());
			end
		end
		r.good_delay = srch.pass_bound;
		r.bad_delay = srch.fail_bound;
		return r;
	endfunction

	// watch all three channels; results are matched before new words are predicted
	always @(posedge clk or negedge arst_n) begin : watch
		dbms_res_t want;
		if (!arst_n) begin
			regs.limit_delay = '0;
			regs.start_delay = 32'd64;
			regs.precision_shift = 5'd4;
			srch.phase = PH_IDLE;
			srch.cur_delay = '0;
			srch.pass_bound = '0;
			srch.fail_bound = '0;
			due_results.delete();
			mismatches = 0;
			n_open <= 0;
			search_live <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0)
					flag("result word with nothing expected");
				else begin
					want = due_results.pop_front();
					check_field("trial_request", DelayW'(trial_request),
							DelayW'(want.trial_request));
					check_field("trial_delay", trial_delay, want.trial_delay);
					check_field("reported", DelayW'(reported), DelayW'(want.reported));
					check_field("reported_delay", reported_delay, want.reported_delay);
					check_field("reported_ok", DelayW'(reported_ok),
							DelayW'(want.reported_ok));
					check_field("done_res", DelayW'(done_res), DelayW'(want.done_res));
					check_field("status", DelayW'(status), DelayW'(want.status));
					check_field("good_delay", good_delay, want.good_delay);
					check_field("bad_delay", bad_delay, want.bad_delay);
				end
			end
			if (in_valid && !in_stall)
				due_results.push_back(search_step(operation, trial_ok, abort_requested));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LIMIT: regs.limit_delay = cfg_data;
					REG_START: regs.start_delay = cfg_data;
					REG_SHIFT: regs.precision_shift = cfg_data[ShiftW-1:0];
					default: ;
				endcase
			end
			n_open <= due_results.size();
			search_live <= (srch.phase != PH_IDLE);
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Margin search testbench top: clock, reset, stimulus, backpressure and the verdict.
module tb_top import dbms_pkg::*;;

	localparam logic [DelayW-1:0] LimitDefault = 32'd1048576;
	localparam int RunLimit = 500000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               operation;
	logic               trial_ok;
	logic               abort_requested;
	logic               out_valid;
	logic               out_stall;
	logic               trial_request;
	logic [DelayW-1:0]  trial_delay;
	logic               reported;
	logic [DelayW-1:0]  reported_delay;
	logic               reported_ok;
	logic               done_res;
	logic [1:0]         status;
	logic [DelayW-1:0]  good_delay;
	logic [DelayW-1:0]  bad_delay;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [DelayW-1:0]  cfg_data;

	int   mismatches;
	int   n_open;
	logic search_live;
	logic calm = 1'b0;
	int   words_sent = 0;
	int   cycles = 0;

	doubling_bisection_margin_search #(.DEFAULT_LIMIT(LimitDefault)) dut (.*);

	dbms_scoreboard #(.LimitDefault(LimitDefault)) u_scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RunLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side stalls in bursts; no new burst starts while calm
	initial begin : result_backpressure
		int hold;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0)
				hold--;
			else if (!calm && $urandom_range(0, 11) == 0)
				hold = $urandom_range(1, 19);
			out_stall <= (hold > 0);
		end
	end

	// send one word, sometimes after an idle burst
	task automatic feed(input logic op, input logic ok, input logic ab);
		if (!calm && $urandom_range(0, 6) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		trial_ok <= ok;
		abort_requested <= ab;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// drain all results, let the pipe settle, then write all three registers
	task automatic set_regs(input logic [DelayW-1:0] lim, input logic [DelayW-1:0] first,
			input logic [DelayW-1:0] shift_word);
		logic [DelayW-1:0]  vals [3];
		logic [CfgIdxW-1:0] idx [3];
		vals = '{lim, first, shift_word};
		idx = '{REG_LIMIT, REG_START, REG_SHIFT};
		in_valid <= 1'b0;
		do @(posedge clk); while (n_open != 0);
		repeat (4) @(posedge clk);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// one search: start, then outcomes until the search ends or is cut short
	task automatic run_search();
		int n;
		int cut;
		if ($urandom_range(0, 7) == 0)
			feed(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
		feed(OP_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 64;
		n = 0;
		do begin
			// control trial mostly passes, later trials pass about 60% of the time
			feed(OP_REPORT, (n == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 4) < 3),
					$urandom_range(0, 24) == 0);
			n++;
		end while (search_live && n < cut);
	endtask

	initial begin : stimulus
		logic [DelayW-1:0] lim;
		logic [DelayW-1:0] eff;
		logic [DelayW-1:0] first;
		logic [DelayW-1:0] sh;
		int                phase_end;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_START;
		trial_ok <= 1'b0;
		abort_requested <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_LIMIT;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small ramp: limit 128, start 64
		set_regs(32'd128, 32'd64, 32'd4);
		feed(OP_REPORT, 1'b1, 1'b1);        // outcome while idle is ignored
		feed(OP_START, 1'b0, 1'b0);
		feed(OP_REPORT, 1'b0, 1'b0);        // control trial fails
		feed(OP_START, 1'b1, 1'b1);
		feed(OP_REPORT, 1'b1, 1'b1);        // no abort check after control
		feed(OP_REPORT, 1'b1, 1'b0);
		feed(OP_REPORT, 1'b1, 1'b0);        // 256 would pass the limit
		feed(OP_START, 1'b0, 1'b0);
		feed(OP_REPORT, 1'b1, 1'b0);
		feed(OP_REPORT, 1'b1, 1'b0);
		feed(OP_REPORT, 1'b0, 1'b1);        // ramp failure ignores abort, bisect at 96
		feed(OP_REPORT, 1'b1, 1'b1);        // abort during bisection
		feed(OP_START, 1'b0, 1'b0);
		feed(OP_REPORT, 1'b1, 1'b0);
		feed(OP_START, 1'b1, 1'b0);         // restart mid-search
		feed(OP_REPORT, 1'b1, 1'b0);
		feed(OP_REPORT, 1'b1, 1'b1);        // abort after a passing ramp trial

		// default limit, zero start delay counts as one, widest shift
		set_regs('0, '0, 32'd31);
		feed(OP_START, 1'b0, 1'b0);
		feed(OP_REPORT, 1'b1, 1'b0);
		feed(OP_REPORT, 1'b0, 1'b0);

		// start delay already above the limit
		set_regs(32'd5, 32'd6, '0);
		feed(OP_START, 1'b0, 1'b0);
		feed(OP_REPORT, 1'b1, 1'b0);

		// top of the delay range, shift data with upper bits set
		set_regs(32'hFFFF_FFFF, 32'h4000_0000, 32'hFFFF_FFE0);
		feed(OP_START, 1'b0, 1'b0);
		feed(OP_REPORT, 1'b1, 1'b0);
		feed(OP_REPORT, 1'b1, 1'b0);
		feed(OP_REPORT, 1'b0, 1'b1);

		// random phases, each with its own register setting
		while (words_sent < 1150) begin
			calm = (words_sent > 1000) || ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 4))
				0: lim = '0;
				1: lim = 32'hFFFF_FFFF;
				2: lim = $urandom_range(1, 64);
				3: lim = $urandom_range(1, 1 << 16);
				default: lim = $urandom;
			endcase
			eff = (lim == '0) ? LimitDefault : lim;
			case ($urandom_range(0, 5))
				0: first = '0;
				1: first = 32'd1;
				2: first = 32'hFFFF_FFFF;
				3: first = $urandom;
				default: first = (eff >> $urandom_range(1, 12)) + $urandom_range(0, 3);
			endcase
			case ($urandom_range(0, 3))
				0: sh = '0;
				1: sh = 32'd31;
				default: sh = $urandom;
			endcase
			set_regs(lim, first, sh);
			phase_end = words_sent + $urandom_range(50, 110);
			while (words_sent < phase_end)
				run_search();
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (n_open != 0);
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
